>>> rtl/core/ssmc_pkg.sv
`timescale 1ns / 1ps

package ssmc_pkg;

   // Field and state widths
   localparam int unsigned MODE_W   = 2;
   localparam int unsigned EDGES_W  = 4;
   localparam int unsigned SW_W     = 5;
   localparam int unsigned SEG_W    = 7;
   localparam int unsigned LED_W    = 10;
   localparam int unsigned PERIOD_W = 32;
   localparam int unsigned LEVEL_W  = 3;
   localparam int unsigned BASE_W   = 28;
   localparam int unsigned SEL_W    = 3;
   localparam int unsigned LEN_W    = 5;
   localparam int unsigned HEAD_W   = 4;
   localparam int unsigned OUT_DIGITS = 6;
   localparam int unsigned NUM_MSGS   = 6;
   localparam int unsigned GLYPH_SLOTS = 16;

   // Parameter defaults
   localparam int unsigned DEF_NUM_DIGITS         = 6;
   localparam int unsigned DEF_NUM_LEVELS         = 5;
   localparam int unsigned DEF_MAX_MESSAGE_LENGTH = 16;

   localparam logic [BASE_W-1:0] BASE_PERIOD_RESET = 28'd12500000;
   localparam logic [LED_W-1:0]  LED_ALL           = 10'h3FF;

   // Event kinds
   localparam logic [MODE_W-1:0] MODE_TICK     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BUTTONS  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SWITCHES = 2'd2;

   // Button bit positions
   localparam int unsigned BTN_SLOWER  = 0;
   localparam int unsigned BTN_FASTER  = 1;
   localparam int unsigned BTN_REVERSE = 2;
   localparam int unsigned BTN_PAUSE   = 3;

   // Switch patterns that select a message
   localparam logic [SW_W-1:0] SW_COFFEE    = 5'h00;
   localparam logic [SW_W-1:0] SW_CAFES     = 5'h01;
   localparam logic [SW_W-1:0] SW_CABS      = 5'h02;
   localparam logic [SW_W-1:0] SW_ACE       = 5'h04;
   localparam logic [SW_W-1:0] SW_TOAD      = 5'h08;
   localparam logic [SW_W-1:0] SW_BEEF      = 5'h10;

   localparam logic [SEL_W-1:0] SEL_NONE = 3'd0;

   // Glyph rows, one per message, blank padded
   localparam logic [SEG_W-1:0] MSG_GLYPHS [NUM_MSGS][GLYPH_SLOTS] = '{
      '{7'h39, 7'h3F, 7'h71, 7'h71, 7'h79, 7'h79, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00},
      '{7'h39, 7'h77, 7'h71, 7'h79, 7'h6D, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00},
      '{7'h39, 7'h77, 7'h7C, 7'h6D, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00},
      '{7'h77, 7'h39, 7'h79, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00},
      '{7'h07, 7'h3F, 7'h77, 7'h5E, 7'h6D, 7'h07, 7'h3F, 7'h3F,
        7'h06, 7'h6D, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00},
      '{7'h39, 7'h77, 7'h71, 7'h79, 7'h00, 7'h7C, 7'h79, 7'h79,
        7'h71, 7'h00, 7'h39, 7'h3F, 7'h71, 7'h71, 7'h79, 7'h79}
   };

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic apply;
      logic fill;
      logic load_out;
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic need_fill;
      logic fill_last;
   } ctl_status_type;

   // Switch pattern to message number, none when unmatched
   function automatic logic [SEL_W-1:0] decode_switches(input logic [SW_W-1:0] sw);
      logic [SEL_W-1:0] sel;
      case (sw)
         SW_COFFEE: sel = 3'd1;
         SW_CAFES:  sel = 3'd2;
         SW_CABS:   sel = 3'd3;
         SW_ACE:    sel = 3'd4;
         SW_TOAD:   sel = 3'd5;
         SW_BEEF:   sel = 3'd6;
         default:   sel = SEL_NONE;
      endcase
      return sel;
   endfunction

   function automatic logic [LEN_W-1:0] msg_length(input logic [SEL_W-1:0] sel);
      logic [LEN_W-1:0] len;
      case (sel)
         3'd1:    len = 5'd6;
         3'd2:    len = 5'd5;
         3'd3:    len = 5'd4;
         3'd4:    len = 5'd3;
         3'd5:    len = 5'd10;
         3'd6:    len = 5'd16;
         default: len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic logic [SEG_W-1:0] msg_glyph(input logic [SEL_W-1:0] sel,
                                                  input logic [LEN_W-1:0] pos);
      logic [SEL_W-1:0] row;
      logic [SEG_W-1:0] seg;
      row = sel - 3'd1;
      if (sel == SEL_NONE || sel > 3'(NUM_MSGS) || pos >= 5'(GLYPH_SLOTS)) begin
         seg = '0;
      end else begin
         seg = MSG_GLYPHS[row][pos[HEAD_W-1:0]];
      end
      return seg;
   endfunction

endpackage

>>> rtl/core/ssmc_ctrl.sv
`timescale 1ns / 1ps

module ssmc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  ssmc_pkg::ctl_status_type status,
   output ssmc_pkg::ctl_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_FILL,
      ST_EMIT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   // output register free when empty or being drained this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // commands
   always_comb begin
      cmd          = '0;
      cmd.capture  = (state_ff == ST_IDLE) && req_valid;
      cmd.apply    = (state_ff == ST_DECODE);
      cmd.fill     = (state_ff == ST_FILL);
      cmd.load_out = (state_ff == ST_EMIT) && out_free;
   end

   // state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) state_ff <= ST_DECODE;
            end
            ST_DECODE: begin
               state_ff <= status.need_fill ? ST_FILL : ST_EMIT;
            end
            ST_FILL: begin
               if (status.fill_last) state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (out_free) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase

         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

>>> rtl/core/ssmc_datapath.sv
`timescale 1ns / 1ps

module ssmc_datapath #(
   parameter int unsigned NUM_DIGITS         = ssmc_pkg::DEF_NUM_DIGITS,
   parameter int unsigned NUM_LEVELS         = ssmc_pkg::DEF_NUM_LEVELS,
   parameter int unsigned MAX_MESSAGE_LENGTH = ssmc_pkg::DEF_MAX_MESSAGE_LENGTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ssmc_pkg::ctl_cmd_type              cmd,
   output ssmc_pkg::ctl_status_type           status,
   input  logic [ssmc_pkg::MODE_W-1:0]        req_mode,
   input  logic [ssmc_pkg::EDGES_W-1:0]       req_button_edges,
   input  logic [ssmc_pkg::SW_W-1:0]          req_switches,
   input  logic                               csr_wr_en,
   input  logic [ssmc_pkg::BASE_W-1:0]        csr_wr_data,
   output logic [ssmc_pkg::SEG_W-1:0]         rsp_digits [ssmc_pkg::OUT_DIGITS],
   output logic [ssmc_pkg::LED_W-1:0]         rsp_led_bar,
   output logic [ssmc_pkg::PERIOD_W-1:0]      rsp_tick_period,
   output logic [ssmc_pkg::LEVEL_W-1:0]       rsp_speed_level
);

   localparam int unsigned IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
   localparam logic [ssmc_pkg::LEVEL_W-1:0] TOP_LEVEL =
      ssmc_pkg::LEVEL_W'(NUM_LEVELS - 1);
   localparam logic [ssmc_pkg::LEVEL_W-1:0] RESET_LEVEL =
      (NUM_LEVELS - 1 < 2) ? ssmc_pkg::LEVEL_W'(NUM_LEVELS - 1) : 3'd2;
   localparam int unsigned SHIFT_W = ssmc_pkg::BASE_W + 7;

   // captured item
   logic [ssmc_pkg::MODE_W-1:0]  mode_ff;
   logic [ssmc_pkg::EDGES_W-1:0] edges_ff;
   logic [ssmc_pkg::SW_W-1:0]    sw_ff;

   // marquee state
   logic [ssmc_pkg::BASE_W-1:0]  base_ff,    base_in;
   logic [ssmc_pkg::LEVEL_W-1:0] level_ff,   level_in;
   logic                         pause_ff,   pause_in;
   logic                         left_ff,    left_in;
   logic [ssmc_pkg::SEL_W-1:0]   sel_ff,     sel_in;
   logic [ssmc_pkg::LEN_W-1:0]   len_ff,     len_in;
   logic [ssmc_pkg::HEAD_W-1:0]  head_ff,    head_in;
   logic [ssmc_pkg::SW_W-1:0]    last_sw_ff, last_sw_in;
   logic                         seen_ff,    seen_in;
   logic [ssmc_pkg::SEG_W-1:0]   shown_ff [NUM_DIGITS];
   logic [ssmc_pkg::SEG_W-1:0]   shown_in [NUM_DIGITS];

   // refill walk
   logic [ssmc_pkg::LEN_W-1:0]   pos_ff,     pos_in;
   logic [IDX_W-1:0]             idx_ff,     idx_in;
   logic                         justify_ff, justify_in;

   // decode helpers
   logic [ssmc_pkg::HEAD_W-1:0]  head_inc, head_dec, head_adv;
   logic                         tick_moves, sw_new;
   logic [ssmc_pkg::SEL_W-1:0]   new_sel;
   logic [ssmc_pkg::LEN_W-1:0]   new_len, tbl_len;
   logic [ssmc_pkg::LEVEL_W-1:0] lvl_up, lvl_dn;
   logic [ssmc_pkg::SEG_W-1:0]   fill_seg;

   // result build
   logic [3:0]                   lvl_plus;
   logic [4:0]                   led_cnt;
   logic [ssmc_pkg::LED_W-1:0]   led_mask;
   logic [SHIFT_W-1:0]           period_wide;
   logic [ssmc_pkg::PERIOD_W-1:0] period_sat;
   logic [ssmc_pkg::SEG_W-1:0]   digit_out [ssmc_pkg::OUT_DIGITS];

   // head step in either direction, wrapping on the message length
   assign head_inc = ((5'(head_ff) + 5'd1) == len_ff) ? '0 : head_ff + 4'd1;
   assign head_dec = (head_ff == '0) ? ssmc_pkg::HEAD_W'(len_ff - 5'd1) : head_ff - 4'd1;
   assign head_adv = left_ff ? head_inc : head_dec;

   assign tick_moves = !pause_ff && (sel_ff != ssmc_pkg::SEL_NONE) && (len_ff != '0);
   assign sw_new     = !seen_ff || (sw_ff != last_sw_ff);

   // new message and its length, cut to the maximum
   assign new_sel = ssmc_pkg::decode_switches(sw_ff);
   assign tbl_len = ssmc_pkg::msg_length(new_sel);
   assign new_len = (6'(tbl_len) > 6'(MAX_MESSAGE_LENGTH)) ?
                    ssmc_pkg::LEN_W'(MAX_MESSAGE_LENGTH) : tbl_len;

   // one digit per fill step; blanks past the end on a fresh message
   assign fill_seg = (justify_ff && (5'(idx_ff) >= len_ff)) ? '0 :
                     ssmc_pkg::msg_glyph(sel_ff, pos_ff);

   assign status.need_fill = ((mode_ff == ssmc_pkg::MODE_TICK) && tick_moves) ||
                             ((mode_ff == ssmc_pkg::MODE_SWITCHES) && sw_new);
   assign status.fill_last = (idx_ff == IDX_W'(NUM_DIGITS - 1));

   // next state
   always_comb begin
      base_in    = base_ff;
      level_in   = level_ff;
      pause_in   = pause_ff;
      left_in    = left_ff;
      sel_in     = sel_ff;
      len_in     = len_ff;
      head_in    = head_ff;
      last_sw_in = last_sw_ff;
      seen_in    = seen_ff;
      shown_in   = shown_ff;
      pos_in     = pos_ff;
      idx_in     = idx_ff;
      justify_in = justify_ff;
      lvl_up     = level_ff;
      lvl_dn     = level_ff;

      if (csr_wr_en) base_in = csr_wr_data;

      if (cmd.apply) begin
         idx_in = '0;
         case (mode_ff)
            ssmc_pkg::MODE_TICK: begin
               if (tick_moves) begin
                  head_in    = head_adv;
                  pos_in     = 5'(head_adv);
                  justify_in = 1'b0;
               end
            end
            ssmc_pkg::MODE_BUTTONS: begin
               // reverse, faster, slower, then pause
               if (!pause_ff) begin
                  if (edges_ff[ssmc_pkg::BTN_REVERSE]) left_in = !left_ff;
                  if (edges_ff[ssmc_pkg::BTN_FASTER] && level_ff < TOP_LEVEL)
                     lvl_up = level_ff + 3'd1;
                  lvl_dn = lvl_up;
                  if (edges_ff[ssmc_pkg::BTN_SLOWER] && lvl_up != '0)
                     lvl_dn = lvl_up - 3'd1;
                  level_in = lvl_dn;
               end
               if (edges_ff[ssmc_pkg::BTN_PAUSE]) pause_in = !pause_ff;
            end
            ssmc_pkg::MODE_SWITCHES: begin
               if (sw_new) begin
                  sel_in     = new_sel;
                  len_in     = new_len;
                  head_in    = '0;
                  last_sw_in = sw_ff;
                  seen_in    = 1'b1;
                  pos_in     = '0;
                  justify_in = 1'b1;
               end
            end
            default: ;
         endcase
      end

      // shift the new digit in from the right
      if (cmd.fill) begin
         for (int k = 0; k < int'(NUM_DIGITS) - 1; k++) begin
            shown_in[k] = shown_ff[k+1];
         end
         shown_in[NUM_DIGITS-1] = fill_seg;
         pos_in = ((pos_ff + 5'd1) == len_ff) ? '0 : pos_ff + 5'd1;
         idx_in = idx_ff + 1'b1;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= ssmc_pkg::BASE_PERIOD_RESET;
         level_ff   <= RESET_LEVEL;
         pause_ff   <= 1'b0;
         left_ff    <= 1'b1;
         sel_ff     <= ssmc_pkg::SEL_NONE;
         len_ff     <= '0;
         head_ff    <= '0;
         last_sw_ff <= '0;
         seen_ff    <= 1'b0;
         idx_ff     <= '0;
         for (int k = 0; k < int'(NUM_DIGITS); k++) shown_ff[k] <= '0;
      end else begin
         base_ff    <= base_in;
         level_ff   <= level_in;
         pause_ff   <= pause_in;
         left_ff    <= left_in;
         sel_ff     <= sel_in;
         len_ff     <= len_in;
         head_ff    <= head_in;
         last_sw_ff <= last_sw_in;
         seen_ff    <= seen_in;
         idx_ff     <= idx_in;
         shown_ff   <= shown_in;
      end
   end

   // item capture and walk pointer
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= req_mode;
         edges_ff <= req_button_edges;
         sw_ff    <= req_switches;
      end
      pos_ff     <= pos_in;
      justify_ff <= justify_in;
   end

   // LED bar: two per level, all ten at the top
   assign lvl_plus = 4'(level_ff) + 4'd1;
   assign led_cnt  = {lvl_plus, 1'b0};
   assign led_mask = (led_cnt >= 5'd10) ? ssmc_pkg::LED_ALL :
                     (10'd1 << led_cnt) - 10'd1;

   // period with saturation
   assign period_wide = SHIFT_W'(base_ff) << level_ff;
   assign period_sat  = (|period_wide[SHIFT_W-1:ssmc_pkg::PERIOD_W]) ? '1 :
                        period_wide[ssmc_pkg::PERIOD_W-1:0];

   // digits past the display width read as blank
   for (genvar g = 0; g < int'(ssmc_pkg::OUT_DIGITS); g++) begin : g_digit
      if (g < int'(NUM_DIGITS)) begin : g_live
         assign digit_out[g] = shown_ff[g];
      end else begin : g_blank
         assign digit_out[g] = '0;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_digits      <= digit_out;
         rsp_led_bar     <= pause_ff ? '0 : led_mask;
         rsp_tick_period <= period_sat;
         rsp_speed_level <= level_ff;
      end
   end

endmodule

>>> rtl/core/seven_segment_marquee_controller_core.sv
`timescale 1ns / 1ps
// An item that redraws the digits goes through decode, the digit refill walk and
// emit before its result is valid; any other item goes from decode to emit.
// One item at a time: the refill walk writes one digit per cycle, and the next
// item is taken in the cycle after the result loads.
// Reset (synchronous, active high) restores level 2, running, scrolling left,
// no message, blank digits and base period 12500000.

module seven_segment_marquee_controller_core #(
   parameter int unsigned NUM_DIGITS         = ssmc_pkg::DEF_NUM_DIGITS,
   parameter int unsigned NUM_LEVELS         = ssmc_pkg::DEF_NUM_LEVELS,
   parameter int unsigned MAX_MESSAGE_LENGTH = ssmc_pkg::DEF_MAX_MESSAGE_LENGTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [ssmc_pkg::MODE_W-1:0]        req_mode,
   input  logic [ssmc_pkg::EDGES_W-1:0]       req_button_edges,
   input  logic [ssmc_pkg::SW_W-1:0]          req_switches,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [ssmc_pkg::SEG_W-1:0]         rsp_digit0,
   output logic [ssmc_pkg::SEG_W-1:0]         rsp_digit1,
   output logic [ssmc_pkg::SEG_W-1:0]         rsp_digit2,
   output logic [ssmc_pkg::SEG_W-1:0]         rsp_digit3,
   output logic [ssmc_pkg::SEG_W-1:0]         rsp_digit4,
   output logic [ssmc_pkg::SEG_W-1:0]         rsp_digit5,
   output logic [ssmc_pkg::LED_W-1:0]         rsp_led_bar,
   output logic [ssmc_pkg::PERIOD_W-1:0]      rsp_tick_period,
   output logic [ssmc_pkg::LEVEL_W-1:0]       rsp_speed_level,
   input  logic                               csr_wr_en,
   input  logic [ssmc_pkg::BASE_W-1:0]        csr_wr_data
);

   ssmc_pkg::ctl_cmd_type    cmd;
   ssmc_pkg::ctl_status_type status;
   logic [ssmc_pkg::SEG_W-1:0] digits [ssmc_pkg::OUT_DIGITS];

   ssmc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ssmc_datapath #(
      .NUM_DIGITS         (NUM_DIGITS),
      .NUM_LEVELS         (NUM_LEVELS),
      .MAX_MESSAGE_LENGTH (MAX_MESSAGE_LENGTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_mode         (req_mode),
      .req_button_edges (req_button_edges),
      .req_switches     (req_switches),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_digits       (digits),
      .rsp_led_bar      (rsp_led_bar),
      .rsp_tick_period  (rsp_tick_period),
      .rsp_speed_level  (rsp_speed_level)
   );

   assign rsp_digit0 = digits[0];
   assign rsp_digit1 = digits[1];
   assign rsp_digit2 = digits[2];
   assign rsp_digit3 = digits[3];
   assign rsp_digit4 = digits[4];
   assign rsp_digit5 = digits[5];

endmodule

>>> tb/tb_seven_segment_marquee_controller_core.sv
`timescale 1ns / 1ps

module tb_seven_segment_marquee_controller_core;

   // Widths and codes taken from the package
   localparam int MODE_W      = ssmc_pkg::MODE_W;
   localparam int EDGES_W     = ssmc_pkg::EDGES_W;
   localparam int SW_W        = ssmc_pkg::SW_W;
   localparam int SEG_W       = ssmc_pkg::SEG_W;
   localparam int LED_W       = ssmc_pkg::LED_W;
   localparam int PERIOD_W    = ssmc_pkg::PERIOD_W;
   localparam int LEVEL_W     = ssmc_pkg::LEVEL_W;
   localparam int BASE_W      = ssmc_pkg::BASE_W;
   localparam int OUT_DIGITS  = ssmc_pkg::OUT_DIGITS;
   localparam int NUM_MSGS    = ssmc_pkg::NUM_MSGS;
   localparam int GLYPH_SLOTS = ssmc_pkg::GLYPH_SLOTS;
   localparam int BTN_SLOWER  = ssmc_pkg::BTN_SLOWER;
   localparam int BTN_FASTER  = ssmc_pkg::BTN_FASTER;
   localparam int BTN_REVERSE = ssmc_pkg::BTN_REVERSE;
   localparam int BTN_PAUSE   = ssmc_pkg::BTN_PAUSE;

   localparam logic [MODE_W-1:0]  MODE_TICK         = ssmc_pkg::MODE_TICK;
   localparam logic [MODE_W-1:0]  MODE_BUTTONS      = ssmc_pkg::MODE_BUTTONS;
   localparam logic [MODE_W-1:0]  MODE_SWITCHES     = ssmc_pkg::MODE_SWITCHES;
   localparam logic [SW_W-1:0]    SW_COFFEE         = ssmc_pkg::SW_COFFEE;
   localparam logic [SW_W-1:0]    SW_CAFES          = ssmc_pkg::SW_CAFES;
   localparam logic [SW_W-1:0]    SW_CABS           = ssmc_pkg::SW_CABS;
   localparam logic [SW_W-1:0]    SW_ACE            = ssmc_pkg::SW_ACE;
   localparam logic [SW_W-1:0]    SW_TOAD           = ssmc_pkg::SW_TOAD;
   localparam logic [SW_W-1:0]    SW_BEEF           = ssmc_pkg::SW_BEEF;
   localparam logic [BASE_W-1:0]  BASE_PERIOD_RESET = ssmc_pkg::BASE_PERIOD_RESET;
   localparam logic [LED_W-1:0]   LED_ALL           = ssmc_pkg::LED_ALL;

   localparam int NUM_DIG         = ssmc_pkg::DEF_NUM_DIGITS;
   localparam int TOP_LEVEL       = ssmc_pkg::DEF_NUM_LEVELS - 1;
   localparam int MAX_LEN         = ssmc_pkg::DEF_MAX_MESSAGE_LENGTH;
   localparam int HOLD_CYCLES     = 400;
   localparam int WATCHDOG_CYCLES = 2000;
   localparam int SETTLE_CYCLES   = 20;

   // Mode value with no meaning to the block
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam logic [BASE_W-1:0] BASE_MAX    = 28'hFFFFFFF;
   localparam logic [BASE_W-1:0] BASE_ZERO   = 28'd0;
   localparam logic [BASE_W-1:0] BASE_MIN    = 28'd1;

   // One display frame as reported by the block
   typedef struct packed {
      logic [OUT_DIGITS-1:0][SEG_W-1:0] digit;
      logic [LED_W-1:0]                 led_bar;
      logic [PERIOD_W-1:0]              tick_period;
      logic [LEVEL_W-1:0]               speed_level;
   } marquee_frame_type;

   // Shadow of the marquee state and the frames it should produce
   class marquee_predictor;
      logic [BASE_W-1:0]  base;
      logic [LEVEL_W-1:0] level;
      bit                 paused;
      bit                 scroll_left;
      bit                 sw_seen;
      logic [SW_W-1:0]    last_sw;
      int                 sel;
      int                 len;
      int                 head;
      logic [SEG_W-1:0]   shown [OUT_DIGITS];
      logic [SEG_W-1:0]   glyphs [NUM_MSGS][GLYPH_SLOTS];
      int                 lengths [NUM_MSGS];
      marquee_frame_type  expected_frames [$];
      int                 errors;

      function new();
         glyphs = '{
            '{7'h39, 7'h3F, 7'h71, 7'h71, 7'h79, 7'h79, 7'h00, 7'h00,
              7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00},
            '{7'h39, 7'h77, 7'h71, 7'h79, 7'h6D, 7'h00, 7'h00, 7'h00,
              7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00},
            '{7'h39, 7'h77, 7'h7C, 7'h6D, 7'h00, 7'h00, 7'h00, 7'h00,
              7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00},
            '{7'h77, 7'h39, 7'h79, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
              7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00},
            '{7'h07, 7'h3F, 7'h77, 7'h5E, 7'h6D, 7'h07, 7'h3F, 7'h3F,
              7'h06, 7'h6D, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00},
            '{7'h39, 7'h77, 7'h71, 7'h79, 7'h00, 7'h7C, 7'h79, 7'h79,
              7'h71, 7'h00, 7'h39, 7'h3F, 7'h71, 7'h71, 7'h79, 7'h79}
         };
         lengths = '{6, 5, 4, 3, 10, 16};
         base        = BASE_PERIOD_RESET;
         level       = (2 > TOP_LEVEL) ? LEVEL_W'(TOP_LEVEL) : 3'd2;
         paused      = 1'b0;
         scroll_left = 1'b1;
         sw_seen     = 1'b0;
         last_sw     = '0;
         sel         = 0;
         len         = 0;
         head        = 0;
         errors      = 0;
         foreach (shown[i]) shown[i] = '0;
      endfunction

      function logic [SEG_W-1:0] glyph_at(int pos);
         if (sel < 1 || sel > NUM_MSGS || pos >= GLYPH_SLOTS) return '0;
         return glyphs[sel-1][pos];
      endfunction

      // New message, left-justified with blanks after it
      function void load_message(logic [SW_W-1:0] sw);
         case (sw)
            SW_COFFEE: sel = 1;
            SW_CAFES:  sel = 2;
            SW_CABS:   sel = 3;
            SW_ACE:    sel = 4;
            SW_TOAD:   sel = 5;
            SW_BEEF:   sel = 6;
            default:   sel = 0;
         endcase
         len = 0;
         if (sel != 0) begin
            len = lengths[sel-1];
            if (len > MAX_LEN) len = MAX_LEN;
         end
         head = 0;
         for (int i = 0; i < NUM_DIG; i++)
            shown[i] = (sel != 0 && i < len) ? glyph_at(i) : '0;
      endfunction

      // Move the head one place and redraw
      function void shift_head();
         if (sel == 0 || len == 0) return;
         head = scroll_left ? (head + 1) % len : (head + len - 1) % len;
         for (int i = 0; i < NUM_DIG; i++)
            shown[i] = glyph_at((head + i) % len);
      endfunction

      function marquee_frame_type frame_now();
         marquee_frame_type fr;
         int                leds;
         logic [63:0]       period;
         for (int i = 0; i < OUT_DIGITS; i++)
            fr.digit[i] = (i < NUM_DIG) ? shown[i] : '0;
         leds = (int'(level) + 1) * 2;
         fr.led_bar = paused ? '0 : ((leds >= LED_W) ? LED_ALL : LED_W'((1 << leds) - 1));
         period = 64'(base) << level;
         if (period > 64'hFFFF_FFFF) period = 64'hFFFF_FFFF;
         fr.tick_period = period[PERIOD_W-1:0];
         fr.speed_level = level;
         return fr;
      endfunction

      function void set_base(logic [BASE_W-1:0] value);
         base = value;
      endfunction

      // Accepted input item: update the shadow state and queue the frame
      function void note_event(logic [MODE_W-1:0] mode, logic [EDGES_W-1:0] edges,
                               logic [SW_W-1:0] sw);
         case (mode)
            MODE_TICK: begin
               if (!paused) shift_head();
            end
            MODE_BUTTONS: begin
               if (!paused) begin
                  if (edges[BTN_REVERSE]) scroll_left = !scroll_left;
                  if (edges[BTN_FASTER] && level < TOP_LEVEL) level++;
                  if (edges[BTN_SLOWER] && level > 0) level--;
               end
               if (edges[BTN_PAUSE]) paused = !paused;
            end
            MODE_SWITCHES: begin
               if (!sw_seen || sw != last_sw) begin
                  load_message(sw);
                  last_sw = sw;
                  sw_seen = 1'b1;
               end
            end
            default: ;
         endcase
         expected_frames.push_back(frame_now());
      endfunction

      function void check_frame(marquee_frame_type got);
         marquee_frame_type want;
         if (expected_frames.size() == 0) begin
            $error("result with no item outstanding");
            errors++;
            return;
         end
         want = expected_frames.pop_front();
         for (int i = 0; i < OUT_DIGITS; i++) begin
            if (got.digit[i] !== want.digit[i]) begin
               $error("digit%0d: expected 0x%02h, got 0x%02h", i, want.digit[i], got.digit[i]);
               errors++;
            end
         end
         if (got.led_bar !== want.led_bar) begin
            $error("led_bar: expected 0x%03h, got 0x%03h", want.led_bar, got.led_bar);
            errors++;
         end
         if (got.tick_period !== want.tick_period) begin
            $error("tick_period: expected 0x%08h, got 0x%08h", want.tick_period, got.tick_period);
            errors++;
         end
         if (got.speed_level !== want.speed_level) begin
            $error("speed_level: expected %0d, got %0d", want.speed_level, got.speed_level);
            errors++;
         end
      endfunction

      function int pending();
         return expected_frames.size();
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [MODE_W-1:0]   req_mode = '0;
   logic [EDGES_W-1:0]  req_button_edges = '0;
   logic [SW_W-1:0]     req_switches = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [SEG_W-1:0]    rsp_digit0, rsp_digit1, rsp_digit2;
   logic [SEG_W-1:0]    rsp_digit3, rsp_digit4, rsp_digit5;
   logic [LED_W-1:0]    rsp_led_bar;
   logic [PERIOD_W-1:0] rsp_tick_period;
   logic [LEVEL_W-1:0]  rsp_speed_level;
   logic                csr_wr_en = 1'b0;
   logic [BASE_W-1:0]   csr_wr_data = '0;

   marquee_predictor predictor;
   bit tx_idle  = 1'b1;
   bit rx_idle  = 1'b1;
   bit hold_req = 1'b0;
   int quiet_cycles = 0;

   seven_segment_marquee_controller_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_button_edges (req_button_edges),
      .req_switches     (req_switches),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_digit0       (rsp_digit0),
      .rsp_digit1       (rsp_digit1),
      .rsp_digit2       (rsp_digit2),
      .rsp_digit3       (rsp_digit3),
      .rsp_digit4       (rsp_digit4),
      .rsp_digit5       (rsp_digit5),
      .rsp_led_bar      (rsp_led_bar),
      .rsp_tick_period  (rsp_tick_period),
      .rsp_speed_level  (rsp_speed_level),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      if ($urandom_range(0, 9) < 7) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offer one item and wait until it is taken
   task automatic send_event(logic [MODE_W-1:0] mode, logic [EDGES_W-1:0] edges,
                             logic [SW_W-1:0] sw);
      int gap;
      gap = (tx_idle && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_button_edges <= edges;
      req_switches     <= sw;
      do @(posedge clock); while (!req_ready);
      predictor.note_event(mode, edges, sw);
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (predictor.pending() != 0) @(posedge clock);
   endtask

   // Base period is only written with the block idle
   task automatic write_base(logic [BASE_W-1:0] value);
      stop_sending();
      wait_drained();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      predictor.set_base(value);
   endtask

   // Random item, biased towards valid messages and a running marquee
   task automatic random_event();
      logic [MODE_W-1:0]  mode;
      logic [EDGES_W-1:0] edges;
      logic [SW_W-1:0]    sw;
      logic [SW_W-1:0]    known [6];
      int r;
      known = '{SW_COFFEE, SW_CAFES, SW_CABS, SW_ACE, SW_TOAD, SW_BEEF};
      r = $urandom_range(0, 99);
      if (r < 45)      mode = MODE_TICK;
      else if (r < 70) mode = MODE_BUTTONS;
      else if (r < 95) mode = MODE_SWITCHES;
      else             mode = MODE_UNUSED;
      edges = EDGES_W'($urandom_range(0, 7));
      if (predictor.paused ? ($urandom_range(0, 1) == 0) : ($urandom_range(0, 11) == 0))
         edges[BTN_PAUSE] = 1'b1;
      if ($urandom_range(0, 9) < 7) sw = known[$urandom_range(0, 5)];
      else                          sw = SW_W'($urandom_range(0, 31));
      send_event(mode, edges, sw);
   endtask

   // Random phase; optional long receiver hold-off or a full drain midway
   task automatic run_random(int count, bit with_hold, bit with_drain);
      for (int i = 0; i < count; i++) begin
         if (i > 0 && i % 40 == 0) begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
         end
         if (with_hold && i == 10) hold_req = 1'b1;
         if (with_drain && i == count / 2) begin
            stop_sending();
            wait_drained();
         end
         random_event();
      end
   endtask

   // Receiver: random stalls, plus one long hold-off on request
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            stall = HOLD_CYCLES;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
            if (rx_idle && $urandom_range(0, 3) == 0) stall = pick_gap();
         end
      end
   end

   // Result monitor
   always @(posedge clock) begin
      marquee_frame_type fr;
      if (!reset && rsp_valid && rsp_ready) begin
         fr.digit[0]    = rsp_digit0;
         fr.digit[1]    = rsp_digit1;
         fr.digit[2]    = rsp_digit2;
         fr.digit[3]    = rsp_digit3;
         fr.digit[4]    = rsp_digit4;
         fr.digit[5]    = rsp_digit5;
         fr.led_bar     = rsp_led_bar;
         fr.tick_period = rsp_tick_period;
         fr.speed_level = rsp_speed_level;
         predictor.check_frame(fr);
      end
   end

   // Watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      predictor = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset base period
      send_event(MODE_TICK, 4'h0, 5'h00);           // tick with no message
      send_event(MODE_UNUSED, 4'hF, 5'h1F);         // unknown mode
      send_event(MODE_SWITCHES, 4'h0, SW_COFFEE);   // first sample always applies
      send_event(MODE_SWITCHES, 4'hF, SW_COFFEE);   // unchanged sample
      send_event(MODE_TICK, 4'h0, 5'h00);
      send_event(MODE_TICK, 4'h0, 5'h00);
      send_event(MODE_BUTTONS, 4'b0100, 5'h00);     // reverse
      send_event(MODE_TICK, 4'h0, 5'h00);
      send_event(MODE_BUTTONS, 4'b0010, 5'h00);     // faster up to the top
      send_event(MODE_BUTTONS, 4'b0010, 5'h00);
      send_event(MODE_BUTTONS, 4'b0010, 5'h00);
      send_event(MODE_BUTTONS, 4'b0111, 5'h00);     // several bits at once
      send_event(MODE_BUTTONS, 4'b1000, 5'h00);     // pause
      send_event(MODE_TICK, 4'h0, 5'h00);           // tick while paused
      send_event(MODE_BUTTONS, 4'b0111, 5'h00);     // ignored while paused
      send_event(MODE_BUTTONS, 4'b1000, 5'h1F);     // resume
      send_event(MODE_SWITCHES, 4'h0, SW_BEEF);     // longest message
      send_event(MODE_TICK, 4'h0, 5'h00);
      send_event(MODE_SWITCHES, 4'h0, SW_TOAD);
      send_event(MODE_SWITCHES, 4'h0, SW_ACE);
      send_event(MODE_SWITCHES, 4'h0, SW_CABS);
      send_event(MODE_SWITCHES, 4'h0, SW_CAFES);
      send_event(MODE_SWITCHES, 4'h0, 5'h1F);       // unmatched pattern
      send_event(MODE_TICK, 4'hF, 5'h1F);
      send_event(MODE_BUTTONS, 4'b1111, 5'h00);     // all bits, ends paused
      send_event(MODE_BUTTONS, 4'b1000, 5'h00);
      repeat (4) send_event(MODE_BUTTONS, 4'b0001, 5'h00);  // slower down to zero

      // Random phases over a spread of base periods
      write_base(BASE_MIN);
      run_random(130, 1'b0, 1'b0);

      write_base(BASE_MAX);
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      run_random(130, 1'b1, 1'b0);

      write_base(BASE_W'($urandom_range(1, 28'hFFFFFFF)));
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      run_random(130, 1'b0, 1'b1);

      write_base(BASE_ZERO);
      run_random(40, 1'b0, 1'b0);

      write_base(BASE_W'($urandom_range(1, 1000)));
      run_random(130, 1'b0, 1'b0);

      write_base(BASE_W'($urandom_range(1, 28'hFFFFFFF)));
      run_random(90, 1'b0, 1'b0);

      stop_sending();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (predictor.errors == 0 && predictor.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/ssmc_pkg.sv
rtl/core/ssmc_ctrl.sv
rtl/core/ssmc_datapath.sv
rtl/core/seven_segment_marquee_controller_core.sv
tb/tb_seven_segment_marquee_controller_core.sv
